>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/lrukv_pkg.sv
// Package for the LRU key-value cache: sizes, operation codes and constants.
package lrukv_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_W       = 5;
   localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KEY_W       = 32;
   localparam int DATA_W      = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
   localparam logic [DATA_W-1:0] READ_MISS = '1;   // -1 on a get that misses

   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_SET = 1'b1
   } kind_type;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

endpackage

>>> sv/lrukv_ifs.sv
// Handshake interfaces for the request, response and CSR channels.
interface lrukv_req_if;
   logic                             valid;
   logic                             ready;
   lrukv_pkg::kind_type              kind;
   logic signed [lrukv_pkg::KEY_W-1:0]  key;
   logic signed [lrukv_pkg::DATA_W-1:0] value;
   modport source (output valid, kind, key, value, input ready);
   modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lrukv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic signed [lrukv_pkg::DATA_W-1:0] read_value;
   logic                                evicted;
   logic signed [lrukv_pkg::KEY_W-1:0]  evicted_key;
   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lrukv_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lrukv_pkg::CAP_W-1:0]    data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> sv/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
//
//   channel   | dir | transaction
//   ----------+-----+------------------------------------------------
//   req_bus   | in  | kind (get/set), key, value
//   rsp_bus   | out | hit, read_value, evicted, evicted_key
//   csr_bus   | in  | capacity_in_use write (always ready)
//
// Each request passes through ST_IDLE to be accepted, ST_SCAN for every entry in turn
// through the single shared key comparator, and ST_UPDATE.
// The update cycle waits only while the previous response is still held.
// Synchronous active-high reset clears valid bits, ranks, occupancy and
// sets the capacity to 16; no clearing pass is needed.
// req_bus.ready is high only while the sequencer is idle.
`include "assert_macros.svh"

module lru_key_value_cache (
   input  logic       clock,
   input  logic       reset,
   lrukv_req_if.sink   req_bus,
   lrukv_rsp_if.source rsp_bus,
   lrukv_csr_if.sink   csr_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   localparam int N = lrukv_pkg::MAX_ENTRIES;

   state_type state_ff, state_in;
   lrukv_pkg::idx_type idx_ff, idx_in;

   // latched request
   lrukv_pkg::kind_type            op_kind_ff, op_kind_in;
   logic [lrukv_pkg::KEY_W-1:0]    op_key_ff, op_key_in;
   logic [lrukv_pkg::DATA_W-1:0]   op_value_ff, op_value_in;

   // scan results
   logic                           found_ff, found_in;
   lrukv_pkg::idx_type             found_idx_ff, found_idx_in;
   lrukv_pkg::idx_type             found_rank_ff, found_rank_in;
   logic                           any_ff, any_in;
   lrukv_pkg::idx_type             vic_idx_ff, vic_idx_in;
   lrukv_pkg::idx_type             vic_rank_ff, vic_rank_in;
   logic [lrukv_pkg::KEY_W-1:0]    vic_key_ff, vic_key_in;
   logic                           free_ff, free_in;
   lrukv_pkg::idx_type             free_idx_ff, free_idx_in;

   // entry store
   logic [N-1:0]                   valid_ff, valid_in;
   lrukv_pkg::idx_type             rec_ff [N];
   lrukv_pkg::idx_type             rec_in [N];
   logic [lrukv_pkg::KEY_W-1:0]    entry_key_ff [N];
   logic [lrukv_pkg::KEY_W-1:0]    entry_key_in [N];
   logic [lrukv_pkg::DATA_W-1:0]   entry_data_ff [N];
   logic [lrukv_pkg::DATA_W-1:0]   entry_data_in [N];
   lrukv_pkg::cnt_type             occ_ff, occ_in;
   logic [lrukv_pkg::CAP_W-1:0]    cap_ff, cap_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [lrukv_pkg::DATA_W-1:0]   rsp_read_ff, rsp_read_in;
   logic                           rsp_evicted_ff, rsp_evicted_in;
   logic [lrukv_pkg::KEY_W-1:0]    rsp_evkey_ff, rsp_evkey_in;

   // current scan entry, read through one mux
   logic                           scan_valid;
   logic [lrukv_pkg::KEY_W-1:0]    scan_key;
   lrukv_pkg::idx_type             scan_rank;

   // effective capacity and update decisions
   logic [lrukv_pkg::CMP_W-1:0]    cap_eff;
   logic                           out_free;
   logic                           do_evict;
   lrukv_pkg::idx_type             slot;
   logic [N-1:0]                   valid_kept;

   assign scan_valid = valid_ff[idx_ff];
   assign scan_key   = entry_key_ff[idx_ff];
   assign scan_rank  = rec_ff[idx_ff];

   // zero acts as one, anything above the store size as the store size
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = lrukv_pkg::CMP_W'(1);
      end else if (lrukv_pkg::CMP_W'(cap_ff) > lrukv_pkg::CMP_W'(N)) begin
         cap_eff = lrukv_pkg::CMP_W'(N);
      end else begin
         cap_eff = lrukv_pkg::CMP_W'(cap_ff);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign do_evict = (lrukv_pkg::CMP_W'(occ_ff) >= cap_eff) && any_ff;
   // the freed victim may sit below the first free slot
   assign slot = (do_evict && (!free_ff || vic_idx_ff < free_idx_ff)) ? vic_idx_ff
                                                                      : free_idx_ff;

   always_comb begin
      valid_kept = valid_ff;
      if (do_evict) begin
         valid_kept[vic_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      op_kind_in     = op_kind_ff;
      op_key_in      = op_key_ff;
      op_value_in    = op_value_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_rank_in  = found_rank_ff;
      any_in         = any_ff;
      vic_idx_in     = vic_idx_ff;
      vic_rank_in    = vic_rank_ff;
      vic_key_in     = vic_key_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      valid_in       = valid_ff;
      rec_in         = rec_ff;
      entry_key_in   = entry_key_ff;
      entry_data_in  = entry_data_ff;
      occ_in         = occ_ff;
      cap_in         = cap_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_read_in    = rsp_read_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_evkey_in   = rsp_evkey_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_bus.valid) begin
         cap_in = csr_bus.data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_kind_in  = req_bus.kind;
               op_key_in   = req_bus.key;
               op_value_in = req_bus.value;
               idx_in      = '0;
               found_in    = 1'b0;
               any_in      = 1'b0;
               free_in     = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_valid && scan_key == op_key_ff && !found_ff) begin
               found_in      = 1'b1;
               found_idx_in  = idx_ff;
               found_rank_in = scan_rank;
            end
            // victim: valid entry with the largest rank
            if (scan_valid && (!any_ff || scan_rank > vic_rank_ff)) begin
               any_in      = 1'b1;
               vic_idx_in  = idx_ff;
               vic_rank_in = scan_rank;
               vic_key_in  = scan_key;
            end
            if (!scan_valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            if (idx_ff == lrukv_pkg::IDX_W'(N - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               idx_in = idx_ff + lrukv_pkg::IDX_W'(1);
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = found_ff;
               rsp_evicted_in = 1'b0;
               rsp_evkey_in   = '0;
               rsp_read_in    = '0;
               if (found_ff) begin
                  // touch: entries more recent than the hit age by one
                  for (int i = 0; i < N; i++) begin
                     if (valid_ff[i] && lrukv_pkg::IDX_W'(i) != found_idx_ff &&
                         rec_ff[i] < found_rank_ff) begin
                        rec_in[i] = rec_ff[i] + lrukv_pkg::IDX_W'(1);
                     end
                  end
                  rec_in[found_idx_ff] = '0;
                  if (op_kind_ff == lrukv_pkg::KIND_GET) begin
                     rsp_read_in = entry_data_ff[found_idx_ff];
                  end else begin
                     entry_data_in[found_idx_ff] = op_value_ff;
                  end
               end else if (op_kind_ff == lrukv_pkg::KIND_GET) begin
                  rsp_read_in = lrukv_pkg::READ_MISS;
               end else begin
                  // insertion of a new key, evicting first when full
                  rsp_evicted_in = do_evict;
                  if (do_evict) begin
                     rsp_evkey_in = vic_key_ff;
                  end
                  for (int i = 0; i < N; i++) begin
                     if (valid_kept[i]) begin
                        rec_in[i] = rec_ff[i] + lrukv_pkg::IDX_W'(1);
                     end
                  end
                  valid_in             = valid_kept;
                  valid_in[slot]       = 1'b1;
                  rec_in[slot]         = '0;
                  entry_key_in[slot]   = op_key_ff;
                  entry_data_in[slot]  = op_value_ff;
                  if (!do_evict) begin
                     occ_in = occ_ff + lrukv_pkg::CNT_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         any_ff       <= 1'b0;
         free_ff      <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= lrukv_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            rec_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         any_ff       <= any_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         rec_ff       <= rec_in;
      end
      op_kind_ff     <= op_kind_in;
      op_key_ff      <= op_key_in;
      op_value_ff    <= op_value_in;
      found_idx_ff   <= found_idx_in;
      found_rank_ff  <= found_rank_in;
      vic_idx_ff     <= vic_idx_in;
      vic_rank_ff    <= vic_rank_in;
      vic_key_ff     <= vic_key_in;
      free_idx_ff    <= free_idx_in;
      entry_key_ff   <= entry_key_in;
      entry_data_ff  <= entry_data_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evkey_ff   <= rsp_evkey_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.hit         = rsp_hit_ff;
   assign rsp_bus.read_value  = rsp_read_ff;
   assign rsp_bus.evicted     = rsp_evicted_ff;
   assign rsp_bus.evicted_key = rsp_evkey_ff;

   // occupancy tracks the valid bits
   `ASSERT_ALWAYS(a_occ_matches_valid, clock, reset, $countones(valid_ff) == int'(occ_ff), "occupancy count differs from valid bits")
   `ASSERT_ALWAYS(a_occ_bounded, clock, reset, int'(occ_ff) <= N, "occupancy above store size")
   // an eviction only comes from a set that missed
   `ASSERT_IMPLIES(a_evict_no_hit, clock, reset, rsp_valid_ff && rsp_evicted_ff, !rsp_hit_ff, "eviction reported on a hit")
   // a held response stays up and the update waits behind it
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_bus.ready, rsp_valid_in && (state_ff != ST_UPDATE || state_in == ST_UPDATE), "response overwritten while held")

endmodule

>>> tb/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key-value cache: mirror model, stimulus and checks.
`timescale 1ns / 100ps

// One response transaction as the cache returns it.
typedef struct packed {
   logic        hit;
   logic [31:0] read_value;
   logic        evicted;
   logic [31:0] evicted_key;
} lookup_outcome_type;

// Mirror of the cache contents; queues the response each request should give.
class lru_cache_mirror;
   bit          slot_live [lrukv_pkg::MAX_ENTRIES];
   logic [31:0] slot_key  [lrukv_pkg::MAX_ENTRIES];
   logic [31:0] slot_data [lrukv_pkg::MAX_ENTRIES];
   logic [3:0]  slot_rank [lrukv_pkg::MAX_ENTRIES];
   int unsigned occupancy;
   logic [4:0]  capacity;
   lookup_outcome_type expected_lookups[$];
   int unsigned mismatches;

   function new();
      foreach (slot_live[i]) begin
         slot_live[i] = 1'b0;
         slot_rank[i] = '0;
      end
      occupancy  = 0;
      capacity   = lrukv_pkg::CAP_RESET;
      mismatches = 0;
   endfunction

   task report(string msg);
      mismatches++;
      if (mismatches <= 60)
         $display("%0t ns  lru check: %s", $time, msg);
   endtask

   function void predict_lookup(lrukv_pkg::kind_type op, logic [31:0] k, logic [31:0] v);
      lookup_outcome_type outcome;
      int limit;
      int found;
      int victim;
      int spare;
      outcome = '0;
      found   = -1;
      victim  = -1;
      spare   = -1;
      // zero behaves as one, anything past the array size as the array size
      limit = (capacity == 0) ? 1 :
              (capacity > lrukv_pkg::MAX_ENTRIES) ? lrukv_pkg::MAX_ENTRIES : int'(capacity);
      foreach (slot_live[i])
         if (found < 0 && slot_live[i] && slot_key[i] == k) found = i;
      if (found >= 0) begin
         outcome.hit = 1'b1;
         if (op == lrukv_pkg::KIND_GET) outcome.read_value = slot_data[found];
         else slot_data[found] = v;
         // entries more recent than the touched one age by one
         foreach (slot_live[i])
            if (slot_live[i] && slot_rank[i] < slot_rank[found]) slot_rank[i]++;
         slot_rank[found] = '0;
      end else if (op == lrukv_pkg::KIND_GET) begin
         outcome.read_value = lrukv_pkg::READ_MISS;
      end else begin
         if (occupancy >= limit) begin
            foreach (slot_live[i])
               if (slot_live[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                  victim = i;
            if (victim >= 0) begin
               outcome.evicted     = 1'b1;
               outcome.evicted_key = slot_key[victim];
               slot_live[victim]   = 1'b0;
               occupancy--;
            end
         end
         foreach (slot_live[i]) begin
            if (!slot_live[i] && spare < 0) spare = i;
            if (slot_live[i]) slot_rank[i]++;
         end
         slot_live[spare] = 1'b1;
         slot_key[spare]  = k;
         slot_data[spare] = v;
         slot_rank[spare] = '0;
         occupancy++;
      end
      expected_lookups.push_back(outcome);
   endfunction

   task check_lookup(lookup_outcome_type got);
      lookup_outcome_type want;
      if (expected_lookups.size() == 0) begin
         report("response with no request outstanding");
         return;
      end
      want = expected_lookups.pop_front();
      if (got.hit !== want.hit)
         report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
      if (got.read_value !== want.read_value)
         report($sformatf("read_value %h, expected %h", got.read_value, want.read_value));
      if (got.evicted !== want.evicted)
         report($sformatf("evicted %0b, expected %0b", got.evicted, want.evicted));
      if (got.evicted_key !== want.evicted_key)
         report($sformatf("evicted_key %h, expected %h", got.evicted_key, want.evicted_key));
   endtask
endclass

module lru_key_value_cache_test;

   localparam logic [31:0] WORD_MIN = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_NEG = 32'hFFFF_FFFF;
   localparam int          PHASES   = 12;

   logic clock;
   logic reset;

   lrukv_req_if req_bus ();
   lrukv_rsp_if rsp_bus ();
   lrukv_csr_if csr_bus ();

   lru_key_value_cache dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   lru_cache_mirror mirror = new();

   // Keys drawn for the current phase; a small pool keeps hits frequent.
   logic [31:0] key_pool[32];
   // When set, neither side idles for the whole phase.
   bit          calm_phase;
   // Long receiver hold-off, counted down by the response process.
   int          hold_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Generous ceiling on the length of the whole run.
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Mostly back-to-back, some short gaps, the odd long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_phase || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Data word with the extremes turning up now and then.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return WORD_NEG;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // Offer one request transaction; valid stays up if the next one follows at once.
   task automatic send_request(lrukv_pkg::kind_type op, logic [31:0] k, logic [31:0] v);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= op;
      req_bus.key   <= k;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      mirror.predict_lookup(op, k, v);
   endtask

   // Stop offering and wait until every outstanding response has been seen.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (mirror.expected_lookups.size() != 0) @(posedge clock);
   endtask

   // Capacity changes only with the cache idle.
   task automatic write_capacity(logic [4:0] cap);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= cap;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      mirror.capacity = cap;
   endtask

   // Random gets and sets over the key pool, with a few stray keys.
   task automatic random_traffic(int count, int pool_n);
      lrukv_pkg::kind_type op;
      logic [31:0]         k;
      for (int n = 0; n < count; n++) begin
         op = $urandom_range(0, 1) ? lrukv_pkg::KIND_SET : lrukv_pkg::KIND_GET;
         if ($urandom_range(0, 11) == 0) k = $urandom();
         else k = key_pool[$urandom_range(0, pool_n - 1)];
         send_request(op, k, pick_word());
      end
   endtask

   // Response side: checks each accepted transaction, then decides ready.
   initial begin
      lookup_outcome_type seen;
      int                 idle_left;
      idle_left     = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
               seen.hit         = rsp_bus.hit;
               seen.read_value  = rsp_bus.read_value;
               seen.evicted     = rsp_bus.evicted;
               seen.evicted_key = rsp_bus.evicted_key;
               mirror.check_lookup(seen);
            end
            if (hold_cycles > 0) begin
               rsp_bus.ready <= 1'b0;
               hold_cycles--;
            end else if (idle_left > 0) begin
               rsp_bus.ready <= 1'b0;
               idle_left--;
            end else begin
               rsp_bus.ready <= 1'b1;
               if ($urandom_range(0, 99) < 20) idle_left = idle_length();
            end
         end
      end
   end

   // Main sequence.
   initial begin
      logic [4:0] cap;
      int         pool_n;
      calm_phase    = 1'b0;
      hold_cycles   = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= lrukv_pkg::KIND_GET;
      req_bus.key   <= '0;
      req_bus.value <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty lookup, extreme keys and values, update in place.
      send_request(lrukv_pkg::KIND_GET, '0, WORD_MAX);
      send_request(lrukv_pkg::KIND_SET, WORD_MIN, WORD_MAX);
      send_request(lrukv_pkg::KIND_SET, WORD_MAX, WORD_MIN);
      send_request(lrukv_pkg::KIND_SET, '0, '0);
      send_request(lrukv_pkg::KIND_SET, WORD_NEG, WORD_NEG);
      send_request(lrukv_pkg::KIND_GET, WORD_MIN, '0);
      send_request(lrukv_pkg::KIND_GET, WORD_MAX, '0);
      send_request(lrukv_pkg::KIND_GET, WORD_NEG, '0);      // hit returning all ones
      send_request(lrukv_pkg::KIND_SET, '0, 32'h1234_5678);
      send_request(lrukv_pkg::KIND_GET, '0, '0);
      send_request(lrukv_pkg::KIND_GET, 32'h5555_5555, '0); // miss leaves state alone

      // Capacity one: every new key pushes out the least recently used one, with four already held.
      write_capacity(5'd1);
      send_request(lrukv_pkg::KIND_SET, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
      send_request(lrukv_pkg::KIND_SET, 32'h5555_5555, 32'hF0F0_F0F0);
      send_request(lrukv_pkg::KIND_GET, 32'hAAAA_AAAA, '0);
      send_request(lrukv_pkg::KIND_GET, 32'h5555_5555, '0);

      // Capacity zero behaves as one.
      write_capacity(5'd0);
      send_request(lrukv_pkg::KIND_SET, 32'h0000_0001, WORD_MIN);
      send_request(lrukv_pkg::KIND_GET, 32'h0000_0001, '0);

      // Random phases; the fixed ones cover the extremes and a drop below
      // occupancy straight after a full store.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       cap = 5'd31;
            1:       cap = 5'd3;
            2:       cap = 5'd17;
            3:       cap = 5'd16;
            4:       cap = 5'd1;
            5:       cap = 5'd0;
            6:       cap = 5'd8;
            default: cap = 5'($urandom_range(0, 31));
         endcase
         write_capacity(cap);
         calm_phase = (p % 4 == 2);
         // pool somewhat larger than the store so that evictions happen
         pool_n = ((cap > 16) ? 16 : (cap == 0) ? 1 : int'(cap)) + $urandom_range(1, 8);
         if (p == 0) pool_n = 28;
         for (int j = 0; j < 32; j++) key_pool[j] = (j < 2) ? pick_word() : $urandom();
         // receiver holds off while requests keep coming, so the cache backs up
         if (p == 3) hold_cycles = 300;
         random_traffic(140, pool_n);
      end

      drain();
      repeat (40) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
